@@ hw/rtl/annulus_orbit_steering_controller_macros.svh @@
// Assertion macros for the annulus orbit steering controller.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ANNULUS_ORBIT_STEERING_CONTROLLER_MACROS_SVH
`define ANNULUS_ORBIT_STEERING_CONTROLLER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AOSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aosc: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define AOSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aosc: next-cycle check failed");

`endif

@@ hw/rtl/aosc_pkg.sv @@
// Shared types and constants for the annulus orbit steering controller.
// No dependencies.
package aosc_pkg;

    localparam int MAX_TARGETS_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ANGLE_FRAC      = 13;
    localparam int ALIGN_EPS       = 24;
    localparam int ENTRY_W         = 48;
    localparam int COORD_W         = 24;
    localparam int GAIN_W          = 23;
    localparam int MUL_W           = COORD_W + 1;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int SQ_W            = PROD_W;

    localparam logic [1:0] MODE_MOVE  = 2'd0;
    localparam logic [1:0] MODE_ALIGN = 2'd1;
    localparam logic [1:0] MODE_TRAJ  = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ODOM = 1'b1;

    typedef enum logic [2:0] {
        CFG_TARGET_COUNT     = 3'd0,
        CFG_FORWARD_SPEED    = 3'd1,
        CFG_APPROACH_SPEED   = 3'd2,
        CFG_OUTER_RADIUS     = 3'd3,
        CFG_ARRIVE_TOLERANCE = 3'd4,
        CFG_START_HEADING    = 3'd5,
        CFG_CURVATURE_GAIN   = 3'd6
    } cfg_index_t;

    localparam logic [3:0]  RST_TARGET_COUNT     = 4'd2;
    localparam logic [22:0] RST_FORWARD_SPEED    = 23'd6554;
    localparam logic [22:0] RST_APPROACH_SPEED   = 23'd3277;
    localparam logic [22:0] RST_OUTER_RADIUS     = 23'd98304;
    localparam logic [15:0] RST_ARRIVE_TOLERANCE = 16'd66;
    localparam logic [15:0] RST_START_HEADING    = 16'hCDBC;
    localparam logic [22:0] RST_CURVATURE_GAIN   = 23'd32768;

    // Status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ hw/rtl/aosc_table.sv @@
// Target point memory: one write port, one registered read port.
// Depends on aosc_pkg.
module aosc_table
    import aosc_pkg::*;
#(
    parameter int DEPTH = MAX_TARGETS_DEF,
    parameter int AW    = 3
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]      raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/aosc_sqrt.sv @@
// Iterative square root, two radicand bits per cycle, rounded to nearest.
// Depends on aosc_pkg.
module aosc_sqrt
    import aosc_pkg::*;
#(
    parameter int IN_W = SQ_W,
    parameter int RW   = IN_W / 2 + 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [IN_W-1:0] din,
    output unit_stat_t      stat,
    output logic [RW-1:0]   root
);

    logic [IN_W-1:0] n_reg, n_next;
    logic [IN_W-1:0] res_reg, res_next;
    logic [IN_W-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [IN_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = din;
            res_next  = '0;
            bit_next  = IN_W'(1) << (IN_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    // Round up when the remainder exceeds the root
    assign root = res_reg[RW-1:0] + RW'(n_reg > res_reg);
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

@@ hw/rtl/aosc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on aosc_pkg.
module aosc_div
    import aosc_pkg::*;
#(
    parameter int NW = GAIN_W + FRAC_BITS_DEF + 1,
    parameter int DW = SQ_W / 2 + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output unit_stat_t    stat,
    output logic [NW-1:0] quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(shifted - {1'b0, den_reg}) : shifted[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = quo_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

@@ hw/rtl/annulus_orbit_steering_controller.sv @@
// Annulus orbit steering controller: top level with sequencer and shared multiplier.
// Depends on aosc_pkg, aosc_table, aosc_sqrt, aosc_div and the assertion macro header.
//
// Usage: the slave stream carries load items (tuser = 0) that write one target
// point into the table, and odometry items (tuser = 1) that each yield one command
// item on the master stream. The user writes configuration registers on the cfg
// channel while the block is idle, unenforced by the block; cfg_ready is always high.
// Flow: the sequencer works one item at a time, and s_tready is high only while it
// idles. A load item gives no result and leaves the sequencer idle. Move mode passes
// through the read, compare and output states, align mode through multiply, finish
// and output (finish is skipped when the heading is already inside the window).
// Trajectory mode does a memory read, difference, two squares on the shared 25x25
// multiplier and a compare per searched target, then the square root, division and
// output; root and division are skipped at zero gain, division at a zero root. The
// next item can be accepted in the cycle after the result is loaded. The square
// root and the divider steps set the time taken by trajectory items.
// Reset clears the mode to move, loads the register defaults and empties the
// output register; table entries hold nothing until loaded.
// When the receiver stalls, the finished item waits in the output register and
// the next item may be worked until its own result is ready, then it holds.
`include "annulus_orbit_steering_controller_macros.svh"

module annulus_orbit_steering_controller
    import aosc_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // target_index[2:0], target_x[26:3], target_y[50:27], pos_x[74:51],
    // pos_y[98:75], heading[114:99], zero fill [119:115]
    input  logic [119:0] s_tdata,
    // operation[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // linear_speed[22:0], angular_rate[46:23], zero fill [47]
    output logic [47:0]  m_tdata,
    // mode[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [22:0]  cfg_data
);

    localparam int IDX_W   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CW      = $clog2(MAX_TARGETS + 1);
    localparam int IDX_EXT = (IDX_W > 3) ? IDX_W : 3;
    localparam int RW      = SQ_W / 2 + 1;
    localparam int NUM_W   = GAIN_W + FRAC_BITS + 1;
    localparam int ALIGN_BIAS = ((1 << FRAC_BITS) + 5) / 10;
    localparam int ALIGN_GAIN = ((1 << FRAC_BITS) * 4) / 100;
    localparam logic signed [PROD_W-1:0] BIAS_S   = PROD_W'(ALIGN_BIAS);
    localparam logic signed [PROD_W-1:0] HALF_S   = PROD_W'(1) <<< (ANGLE_FRAC - 1);
    localparam logic signed [PROD_W-1:0] RMAX_S   = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] RMIN_S   = -PROD_W'(8388608);
    localparam logic signed [16:0]       EPS_S    = 17'(ALIGN_EPS);
    localparam logic [23:0]              RATE_POS = 24'h7FFFFF;
    localparam logic [23:0]              RATE_NEG = 24'h800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE_RD,
        ST_MOVE_CMP,
        ST_ALIGN_MUL,
        ST_ALIGN_FIN,
        ST_SCAN_RD,
        ST_SCAN_DIF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } state_t;

    // Input fields
    logic [2:0]  in_index;
    logic [23:0] in_tx, in_ty, in_px, in_py;
    logic [15:0] in_heading;

    assign in_index   = s_tdata[2:0];
    assign in_tx      = s_tdata[26:3];
    assign in_ty      = s_tdata[50:27];
    assign in_px      = s_tdata[74:51];
    assign in_py      = s_tdata[98:75];
    assign in_heading = s_tdata[114:99];

    // Control state
    state_t      state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [22:0] lin_out_reg, lin_out_next;
    logic [23:0] ang_out_reg, ang_out_next;
    logic [1:0]  mode_out_reg, mode_out_next;
    logic [3:0]  tcount_reg, tcount_next;
    logic [22:0] fwd_reg, fwd_next;
    logic [22:0] appr_reg, appr_next;
    logic [22:0] outer_reg, outer_next;
    logic [15:0] tol_reg, tol_next;
    logic [15:0] sh_reg, sh_next;
    logic [22:0] gain_reg, gain_next;

    // Working registers
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [23:0]              px_reg, px_next;
    logic [23:0]              py_reg, py_next;
    logic [15:0]              hd_reg, hd_next;
    logic signed [MUL_W-1:0]  dx_reg, dx_next;
    logic signed [MUL_W-1:0]  dy_reg, dy_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SQ_W-1:0]          acc_reg, acc_next;
    logic [SQ_W-1:0]          best_reg, best_next;
    logic [22:0]              res_lin_reg, res_lin_next;
    logic [23:0]              res_ang_reg, res_ang_next;
    logic [1:0]               res_mode_reg, res_mode_next;

    // Shared multiplier operands
    logic signed [MUL_W-1:0] mul_a, mul_b;

    // Table port
    logic               tbl_we;
    logic [IDX_EXT-1:0] load_ext;
    logic [ENTRY_W-1:0] tbl_rdata;
    logic [23:0]        rd_x, rd_y;
    logic               load_ok;
    logic [CW-1:0]      cnt_sat;

    // Iterative units
    logic             sq_start, dv_start;
    unit_stat_t       sq_stat, dv_stat;
    logic [RW-1:0]    root;
    logic [NUM_W-1:0] dv_num, quot;
    logic [23:0]      q_clamp;

    // Datapath helpers
    logic signed [25:0]       move_d;
    logic [25:0]              move_abs;
    logic                     move_near;
    logic signed [16:0]       err;
    logic                     err_big;
    logic signed [PROD_W-1:0] rnd_pos, rnd_neg, term, ang_full;
    logic [23:0]              ang_sat;
    logic [SQ_W-1:0]          sq_sum, scan_best;
    logic                     scan_last;

    assign load_ext = IDX_EXT'(in_index);
    assign load_ok  = 32'(in_index) < MAX_TARGETS;
    assign cnt_sat  = (32'(tcount_reg) > MAX_TARGETS) ? CW'(MAX_TARGETS) : CW'(tcount_reg);
    assign rd_x     = tbl_rdata[23:0];
    assign rd_y     = tbl_rdata[47:24];

    aosc_table #(
        .DEPTH (MAX_TARGETS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (load_ext[IDX_W-1:0]),
        .wdata ({in_ty, in_tx}),
        .raddr (idx_reg),
        .rdata (tbl_rdata)
    );

    aosc_sqrt #(
        .IN_W (SQ_W),
        .RW   (RW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .din   (scan_best),
        .stat  (sq_stat),
        .root  (root)
    );

    aosc_div #(
        .NW (NUM_W),
        .DW (RW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (root),
        .stat  (dv_stat),
        .quot  (quot)
    );

    // Move: distance of x from the arrival line
    assign move_d    = $signed({{2{rd_x[23]}}, rd_x}) + $signed({3'b000, outer_reg})
                     - $signed({{2{px_reg[23]}}, px_reg});
    assign move_abs  = move_d[25] ? 26'(-move_d) : 26'(move_d);
    assign move_near = move_abs < {10'd0, tol_reg};

    // Align: heading error, rounded gain term and bias
    assign err      = $signed({sh_reg[15], sh_reg}) - $signed({hd_reg[15], hd_reg});
    assign err_big  = (err > EPS_S) || (err < -EPS_S);
    assign rnd_pos  = (prod_reg + HALF_S) >>> ANGLE_FRAC;
    assign rnd_neg  = (-prod_reg + HALF_S) >>> ANGLE_FRAC;
    assign term     = prod_reg[PROD_W-1] ? -rnd_neg : rnd_pos;
    assign ang_full = term + ((err > 17'sd0) ? BIAS_S : -BIAS_S);
    assign ang_sat  = (ang_full > RMAX_S) ? RATE_POS :
                      (ang_full < RMIN_S) ? RATE_NEG : ang_full[23:0];

    // Trajectory: running minimum of squared distance
    assign sq_sum    = acc_reg + SQ_W'(prod_reg);
    assign scan_best = ((idx_reg == '0) || (sq_sum < best_reg)) ? sq_sum : best_reg;
    assign scan_last = (CW'(idx_reg) + CW'(1)) == cnt_reg;
    assign dv_num    = NUM_W'({gain_reg, FRAC_BITS'(0)}) + NUM_W'(root[RW-1:1]);
    assign q_clamp   = (quot > NUM_W'(24'h800000)) ? RATE_NEG : quot[23:0];

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        m_tvalid_next = m_tvalid_reg;
        lin_out_next  = lin_out_reg;
        ang_out_next  = ang_out_reg;
        mode_out_next = mode_out_reg;
        tcount_next   = tcount_reg;
        fwd_next      = fwd_reg;
        appr_next     = appr_reg;
        outer_next    = outer_reg;
        tol_next      = tol_reg;
        sh_next       = sh_reg;
        gain_next     = gain_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        hd_next       = hd_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        acc_next      = acc_reg;
        best_next     = best_reg;
        res_lin_next  = res_lin_reg;
        res_ang_next  = res_ang_reg;
        res_mode_next = res_mode_reg;
        mul_a         = '0;
        mul_b         = '0;
        tbl_we        = 1'b0;
        sq_start      = 1'b0;
        dv_start      = 1'b0;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET_COUNT:     tcount_next = cfg_data[3:0];
                CFG_FORWARD_SPEED:    fwd_next    = cfg_data;
                CFG_APPROACH_SPEED:   appr_next   = cfg_data;
                CFG_OUTER_RADIUS:     outer_next  = cfg_data;
                CFG_ARRIVE_TOLERANCE: tol_next    = cfg_data[15:0];
                CFG_START_HEADING:    sh_next     = cfg_data[15:0];
                CFG_CURVATURE_GAIN:   gain_next   = cfg_data;
                default:              tcount_next = tcount_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    px_next  = in_px;
                    py_next  = in_py;
                    hd_next  = in_heading;
                    idx_next = '0;
                    cnt_next = cnt_sat;
                    if (s_tuser == OP_LOAD)
                    begin
                        tbl_we = load_ok;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_MOVE:  state_next = ST_MOVE_RD;
                            MODE_ALIGN: state_next = ST_ALIGN_MUL;
                            default:
                            begin
                                res_lin_next  = fwd_reg;
                                res_ang_next  = '0;
                                res_mode_next = MODE_TRAJ;
                                state_next    = (cnt_sat == '0) ? ST_OUT : ST_SCAN_RD;
                            end
                        endcase
                    end
                end
            end
            ST_MOVE_RD:
            begin
                state_next = ST_MOVE_CMP;
            end
            ST_MOVE_CMP:
            begin
                res_lin_next  = appr_reg;
                res_ang_next  = '0;
                res_mode_next = move_near ? MODE_ALIGN : MODE_MOVE;
                state_next    = ST_OUT;
            end
            ST_ALIGN_MUL:
            begin
                mul_a        = MUL_W'(err);
                mul_b        = MUL_W'(ALIGN_GAIN);
                res_lin_next = '0;
                if (err_big)
                begin
                    state_next = ST_ALIGN_FIN;
                end
                else
                begin
                    res_ang_next  = '0;
                    res_mode_next = MODE_TRAJ;
                    state_next    = ST_OUT;
                end
            end
            ST_ALIGN_FIN:
            begin
                res_ang_next  = ang_sat;
                res_mode_next = MODE_ALIGN;
                state_next    = ST_OUT;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_DIF;
            end
            ST_SCAN_DIF:
            begin
                dx_next    = $signed({rd_x[23], rd_x}) - $signed({px_reg[23], px_reg});
                dy_next    = $signed({rd_y[23], rd_y}) - $signed({py_reg[23], py_reg});
                state_next = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                mul_a      = dx_reg;
                mul_b      = dx_reg;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                mul_a      = dy_reg;
                mul_b      = dy_reg;
                acc_next   = SQ_W'(prod_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                best_next = scan_best;
                idx_next  = idx_reg + IDX_W'(1);
                if (!scan_last)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (gain_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    sq_start   = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sq_stat.done)
                begin
                    if (root == '0)
                    begin
                        res_ang_next = RATE_NEG;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        dv_start   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (dv_stat.done)
                begin
                    res_ang_next = 24'(-q_clamp);
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    lin_out_next  = res_lin_reg;
                    ang_out_next  = res_ang_reg;
                    mode_out_next = res_mode_reg;
                    mode_next     = res_mode_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_MOVE;
            m_tvalid_reg <= 1'b0;
            lin_out_reg  <= '0;
            ang_out_reg  <= '0;
            mode_out_reg <= MODE_MOVE;
            tcount_reg   <= RST_TARGET_COUNT;
            fwd_reg      <= RST_FORWARD_SPEED;
            appr_reg     <= RST_APPROACH_SPEED;
            outer_reg    <= RST_OUTER_RADIUS;
            tol_reg      <= RST_ARRIVE_TOLERANCE;
            sh_reg       <= RST_START_HEADING;
            gain_reg     <= RST_CURVATURE_GAIN;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
            lin_out_reg  <= lin_out_next;
            ang_out_reg  <= ang_out_next;
            mode_out_reg <= mode_out_next;
            tcount_reg   <= tcount_next;
            fwd_reg      <= fwd_next;
            appr_reg     <= appr_next;
            outer_reg    <= outer_next;
            tol_reg      <= tol_next;
            sh_reg       <= sh_next;
            gain_reg     <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        hd_reg       <= hd_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        res_lin_reg  <= res_lin_next;
        res_ang_reg  <= res_ang_next;
        res_mode_reg <= res_mode_next;
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, ang_out_reg, lin_out_reg};
    assign m_tuser   = mode_out_reg;

    `AOSC_ASSERT_NEXT(a_load_stays_idle, clk, rst_n,
        s_tvalid && s_tready && (s_tuser == OP_LOAD), state_reg == ST_IDLE)
    `AOSC_ASSERT_NOW(a_root_unit_active, clk, rst_n,
        state_reg == ST_ROOT, sq_stat.busy || sq_stat.done)
    `AOSC_ASSERT_NOW(a_div_unit_active, clk, rst_n,
        state_reg == ST_DIV, dv_stat.busy || dv_stat.done)
    `AOSC_ASSERT_NEXT(a_out_loads, clk, rst_n,
        (state_reg == ST_OUT) && !m_tvalid_reg, m_tvalid_reg && (state_reg == ST_IDLE))

endmodule
